// File: src/bcr_pkg.sv
// Shared types and constants of the bisection cubic root block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package bcr_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 24;

   localparam int EPS_W      = 31;
   localparam int ITER_W     = 6;
   localparam int STATUS_W   = 2;
   localparam int LIMB_W     = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [EPS_W-1:0]     EPS_RESET   = 31'd168;
   localparam logic [ITER_W-1:0]    MAXIT_RESET = 6'd40;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER = 1'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_CONVERGED  = 2'd0,
      ST_EXACT_ZERO = 2'd1,
      ST_NO_SIGN    = 2'd2,
      ST_LIMIT      = 2'd3
   } status_type;

   // which point the polynomial unit evaluates
   typedef enum logic [1:0] {
      SEL_LO  = 2'd0,
      SEL_HI  = 2'd1,
      SEL_MID = 2'd2
   } sel_type;

   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_LOAD_X   = 4'd2,
      OP_MAG      = 4'd3,
      OP_FIX      = 4'd4,
      OP_ADD_SQ   = 4'd5,
      OP_ADD_CUBE = 4'd6,
      OP_SAVE_A   = 4'd7,
      OP_MID      = 4'd8,
      OP_UPDATE   = 4'd9,
      OP_OUT      = 4'd10
   } op_type;

   typedef struct packed {
      op_type     op;
      sel_type    sel;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic v_zero;
      logic no_sign;
      logic converged;
      logic at_limit;
      logic out_free;
   } dp_stat_type;

endpackage

// File: src/bcr_if.sv
// Valid/ready channel interfaces: request, response and register write port.
// Depends on bcr_pkg for field widths.
interface bcr_req_if #(parameter int VALUE_WIDTH = bcr_pkg::VALUE_WIDTH_DEF) ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] left_end;
   logic signed [VALUE_WIDTH-1:0] right_end;
   modport source (output valid, output left_end, output right_end, input ready);
   modport sink   (input valid, input left_end, input right_end, output ready);
endinterface

interface bcr_rsp_if #(parameter int VALUE_WIDTH = bcr_pkg::VALUE_WIDTH_DEF) ();
   logic                              valid;
   logic                              ready;
   logic signed [VALUE_WIDTH-1:0]     root;
   logic [VALUE_WIDTH-1:0]            final_width;
   logic [bcr_pkg::ITER_W-1:0]        iterations;
   logic [bcr_pkg::STATUS_W-1:0]      status;
   modport source (output valid, output root, output final_width, output iterations,
                   output status, input ready);
   modport sink   (input valid, input root, input final_width, input iterations,
                   input status, output ready);
endinterface

interface bcr_csr_if ();
   logic                           valid;
   logic                           ready;
   logic [bcr_pkg::CSR_IDX_W-1:0]  index;
   logic [bcr_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/bcr_ctrl.sv
// Sequencer of the bisection search: issues datapath commands, reads status.
// Depends on bcr_pkg (command and status structs).
module bcr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bcr_pkg::dp_stat_type stat,
   output bcr_pkg::cmd_type     cmd
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_LOAD_X = 13'b0000000000010,
      S_MAG1   = 13'b0000000000100,
      S_MUL1   = 13'b0000000001000,
      S_FIX1   = 13'b0000000010000,
      S_ADD1   = 13'b0000000100000,
      S_MAG2   = 13'b0000001000000,
      S_MUL2   = 13'b0000010000000,
      S_FIX2   = 13'b0000100000000,
      S_ADD2   = 13'b0001000000000,
      S_DECIDE = 13'b0010000000000,
      S_MID    = 13'b0100000000000,
      S_CHECK  = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   bcr_pkg::sel_type tgt_ff, tgt_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      tgt_in   = tgt_ff;
      cmd.op   = bcr_pkg::OP_NONE;
      cmd.sel  = tgt_ff;
      cmd.code = bcr_pkg::ST_CONVERGED;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = bcr_pkg::OP_LOAD;
               tgt_in   = bcr_pkg::SEL_LO;
               state_in = S_LOAD_X;
            end
         end
         S_LOAD_X: begin
            cmd.op   = bcr_pkg::OP_LOAD_X;
            state_in = S_MAG1;
         end
         S_MAG1: begin
            cmd.op   = bcr_pkg::OP_MAG;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            if (stat.mul_done) state_in = S_FIX1;
         end
         S_FIX1: begin
            cmd.op   = bcr_pkg::OP_FIX;
            state_in = S_ADD1;
         end
         S_ADD1: begin
            cmd.op   = bcr_pkg::OP_ADD_SQ;
            state_in = S_MAG2;
         end
         S_MAG2: begin
            cmd.op   = bcr_pkg::OP_MAG;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            if (stat.mul_done) state_in = S_FIX2;
         end
         S_FIX2: begin
            cmd.op   = bcr_pkg::OP_FIX;
            state_in = S_ADD2;
         end
         S_ADD2: begin
            cmd.op   = bcr_pkg::OP_ADD_CUBE;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (tgt_ff)
               bcr_pkg::SEL_LO: begin
                  cmd.op   = bcr_pkg::OP_SAVE_A;
                  tgt_in   = bcr_pkg::SEL_HI;
                  state_in = S_LOAD_X;
               end
               bcr_pkg::SEL_HI: begin
                  if (!stat.no_sign) begin
                     state_in = S_MID;
                  end else if (stat.out_free) begin
                     cmd.op   = bcr_pkg::OP_OUT;
                     cmd.code = bcr_pkg::ST_NO_SIGN;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (!stat.v_zero) begin
                     cmd.op   = bcr_pkg::OP_UPDATE;
                     state_in = S_CHECK;
                  end else if (stat.out_free) begin
                     cmd.op   = bcr_pkg::OP_OUT;
                     cmd.code = bcr_pkg::ST_EXACT_ZERO;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_MID: begin
            cmd.op   = bcr_pkg::OP_MID;
            tgt_in   = bcr_pkg::SEL_MID;
            state_in = S_LOAD_X;
         end
         S_CHECK: begin
            if (stat.converged || stat.at_limit) begin
               if (stat.out_free) begin
                  cmd.op   = bcr_pkg::OP_OUT;
                  cmd.code = stat.converged ? bcr_pkg::ST_CONVERGED : bcr_pkg::ST_LIMIT;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_MID;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tgt_ff   <= bcr_pkg::SEL_LO;
      end else begin
         state_ff <= state_in;
         tgt_ff   <= tgt_in;
      end
   end

endmodule

// File: src/bcr_dp.sv
// Datapath: interval registers, limb-serial polynomial unit, config and result registers.
// Depends on bcr_pkg; driven by bcr_ctrl commands.
module bcr_dp #(
   parameter int VALUE_WIDTH = bcr_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = bcr_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bcr_pkg::cmd_type                  cmd,
   output bcr_pkg::dp_stat_type              stat,
   input  logic signed [VALUE_WIDTH-1:0]     left_end,
   input  logic signed [VALUE_WIDTH-1:0]     right_end,
   input  logic                              csr_write,
   input  logic [bcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bcr_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]     rsp_root,
   output logic [VALUE_WIDTH-1:0]            rsp_final_width,
   output logic [bcr_pkg::ITER_W-1:0]        rsp_iterations,
   output logic [bcr_pkg::STATUS_W-1:0]      rsp_status
);

   localparam int VW    = VALUE_WIDTH;
   localparam int FB    = FRAC_BITS;
   localparam int LW    = bcr_pkg::LIMB_W;
   localparam int IW    = bcr_pkg::ITER_W;
   localparam int EW    = bcr_pkg::EPS_W;
   // exact widths of X-4S, (X-4S)X+S^2 and the full cubic
   localparam int T1W   = ((VW > FB + 3) ? VW : FB + 3) + 1;
   localparam int W2    = ((T1W + VW > 2 * FB + 1) ? T1W + VW : 2 * FB + 1) + 1;
   localparam int W3    = ((W2 + VW > 3 * FB + 1) ? W2 + VW : 3 * FB + 1) + 1;
   localparam int ACC_W = W3 + 1;
   localparam int NA    = (W2 + LW - 1) / LW;
   localparam int NB    = (VW + LW - 1) / LW;
   localparam int IA_W  = (NA > 1) ? $clog2(NA) : 1;
   localparam int IB_W  = (NB > 1) ? $clog2(NB) : 1;
   localparam int SH_W  = $clog2(NA + NB);
   localparam int DW    = (VW > EW) ? VW : EW;

   localparam logic [ACC_W-1:0] ONE_ACC = {{(ACC_W-1){1'b0}}, 1'b1};
   localparam logic [ACC_W-1:0] FOUR_S  = ONE_ACC << (FB + 2);
   localparam logic [ACC_W-1:0] S_SQ    = ONE_ACC << (2 * FB);
   localparam logic [ACC_W-1:0] S_CUBE  = ONE_ACC << (3 * FB);
   localparam logic [IA_W-1:0]  IA_LAST = IA_W'(NA - 1);
   localparam logic [IB_W-1:0]  IB_LAST = IB_W'(NB - 1);

   // interval and search state
   logic [VW-1:0]    lo_ff, hi_ff, mid_ff;
   logic [IW-1:0]    iter_ff;
   logic             sa_neg_ff, sa_zero_ff;
   logic [EW-1:0]    eps_ff;
   logic [IW-1:0]    maxit_ff;
   // polynomial unit
   logic [ACC_W-1:0] v_ff;
   logic             xneg_ff, neg_ff;
   logic [VW-1:0]    xmag_ff;
   logic [NA*LW-1:0] a_ff;
   logic [NB*LW-1:0] b_ff;
   logic [ACC_W-1:0] acc_ff;
   logic [IA_W-1:0]  ia_ff;
   logic [IB_W-1:0]  ib_ff;
   logic             busy_ff, pv_ff;
   logic [2*LW-1:0]  prod_ff, prod_in;
   logic [SH_W-1:0]  sh_ff;
   // result register
   logic             rsp_valid_ff;
   logic [VW-1:0]    root_ff, width_ff;
   logic [IW-1:0]    riter_ff;
   logic [bcr_pkg::STATUS_W-1:0] rstat_ff;

   logic [VW-1:0]    x_sel, xmag_in;
   logic [ACC_W-1:0] v_load_in, v_mag, fix_in;
   logic [VW:0]      mid_sum, diff, diff_abs;
   logic [VW-1:0]    width_cur;
   logic [IW-1:0]    limit_eff;
   logic             v_zero, v_neg;
   logic [LW-1:0]    a_limb, b_limb;

   always_comb begin
      case (cmd.sel)
         bcr_pkg::SEL_LO:  x_sel = lo_ff;
         bcr_pkg::SEL_HI:  x_sel = hi_ff;
         default:          x_sel = mid_ff;
      endcase
   end

   assign xmag_in   = x_sel[VW-1] ? (~x_sel + 1'b1) : x_sel;
   assign v_load_in = {{(ACC_W-VW){x_sel[VW-1]}}, x_sel} - FOUR_S;
   assign v_mag     = v_ff[ACC_W-1] ? (~v_ff + 1'b1) : v_ff;
   assign fix_in    = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
   assign v_zero    = (v_ff == '0);
   assign v_neg     = v_ff[ACC_W-1];

   assign a_limb  = a_ff[ia_ff*LW +: LW];
   assign b_limb  = b_ff[ib_ff*LW +: LW];
   assign prod_in = a_limb * b_limb;

   // floor of the half sum is the upper bits of the widened sum
   assign mid_sum   = {lo_ff[VW-1], lo_ff} + {hi_ff[VW-1], hi_ff};
   assign diff      = {lo_ff[VW-1], lo_ff} - {hi_ff[VW-1], hi_ff};
   assign diff_abs  = diff[VW] ? (~diff + 1'b1) : diff;
   assign width_cur = diff_abs[VW-1:0];
   assign limit_eff = (maxit_ff == '0) ? IW'(1) : maxit_ff;

   assign stat.mul_done  = !busy_ff && !pv_ff;
   assign stat.v_zero    = v_zero;
   assign stat.no_sign   = sa_zero_ff || v_zero || (sa_neg_ff == v_neg);
   assign stat.converged = (DW'(width_cur) <= DW'(eps_ff));
   assign stat.at_limit  = (iter_ff >= limit_eff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff   <= bcr_pkg::EPS_RESET;
         maxit_ff <= bcr_pkg::MAXIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            bcr_pkg::CSR_EPSILON:  eps_ff   <= csr_data[EW-1:0];
            bcr_pkg::CSR_MAX_ITER: maxit_ff <= csr_data[IW-1:0];
            default: ;
         endcase
      end
   end

   // interval and polynomial registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         bcr_pkg::OP_LOAD: begin
            lo_ff   <= left_end;
            hi_ff   <= right_end;
            iter_ff <= '0;
         end
         bcr_pkg::OP_LOAD_X: begin
            v_ff    <= v_load_in;
            xneg_ff <= x_sel[VW-1];
            xmag_ff <= xmag_in;
         end
         bcr_pkg::OP_MAG: begin
            a_ff   <= (NA*LW)'(v_mag);
            b_ff   <= (NB*LW)'(xmag_ff);
            neg_ff <= v_neg ^ xneg_ff;
         end
         bcr_pkg::OP_FIX:      v_ff <= fix_in;
         bcr_pkg::OP_ADD_SQ:   v_ff <= v_ff + S_SQ;
         bcr_pkg::OP_ADD_CUBE: v_ff <= v_ff + S_CUBE;
         bcr_pkg::OP_SAVE_A: begin
            sa_neg_ff  <= v_neg;
            sa_zero_ff <= v_zero;
         end
         bcr_pkg::OP_MID: begin
            mid_ff  <= mid_sum[VW:1];
            iter_ff <= iter_ff + 1'b1;
         end
         bcr_pkg::OP_UPDATE: begin
            if (v_neg != sa_neg_ff) hi_ff <= mid_ff;
            else                    lo_ff <= mid_ff;
         end
         default: ;
      endcase
   end

   // limb-serial multiplier: one LWxLW product a cycle, registered and accumulated in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
      end else if (cmd.op == bcr_pkg::OP_MAG) begin
         busy_ff <= 1'b1;
         pv_ff   <= 1'b0;
      end else begin
         pv_ff <= busy_ff;
         if (busy_ff && ib_ff == IB_LAST && ia_ff == IA_LAST) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == bcr_pkg::OP_MAG) begin
         ia_ff  <= '0;
         ib_ff  <= '0;
         acc_ff <= '0;
      end else begin
         if (busy_ff) begin
            prod_ff <= prod_in;
            sh_ff   <= SH_W'(ia_ff) + SH_W'(ib_ff);
            if (ib_ff == IB_LAST) begin
               ib_ff <= '0;
               ia_ff <= ia_ff + 1'b1;
            end else begin
               ib_ff <= ib_ff + 1'b1;
            end
         end
         if (pv_ff) acc_ff <= acc_ff + (ACC_W'(prod_ff) << (sh_ff * LW));
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == bcr_pkg::OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == bcr_pkg::OP_OUT) begin
         rstat_ff <= cmd.code;
         if (cmd.code == bcr_pkg::ST_NO_SIGN) begin
            root_ff  <= '0;
            width_ff <= '0;
            riter_ff <= '0;
         end else begin
            root_ff  <= mid_ff;
            width_ff <= width_cur;
            riter_ff <= iter_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root        = root_ff;
   assign rsp_final_width = width_ff;
   assign rsp_iterations  = riter_ff;
   assign rsp_status      = rstat_ff;

   a_no_sign_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rstat_ff == bcr_pkg::ST_NO_SIGN
      |-> root_ff == '0 && width_ff == '0 && riter_ff == '0)
      else $error("no-sign result carries nonzero fields");

   a_conv_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rstat_ff == bcr_pkg::ST_CONVERGED
      |-> DW'(width_ff) <= DW'(eps_ff))
      else $error("converged result wider than epsilon");

   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rstat_ff == bcr_pkg::ST_LIMIT |-> riter_ff == limit_eff)
      else $error("limit result with wrong iteration count");

   a_acc_after_issue: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> $past(busy_ff))
      else $error("product accumulated without an issue");

endmodule

// File: src/bisection_cubic_root_top.sv
// Top level of the bisection root finder for p(x) = x^3 - 4x^2 + x + 1.
// Depends on bcr_pkg, bcr_if (channels), bcr_ctrl and bcr_dp.
//
// Each request transaction carries two signed fixed-point interval ends. The
// block checks for a sign change of p between them and, if there is one, halves
// the interval until its width is at most epsilon, p hits zero at a midpoint,
// or max_iterations halvings are done; one response transaction follows each
// request. One item is in flight at a time. p is evaluated exactly and only its
// sign is used; each evaluation runs through a limb-serial 32x32 multiplier,
// NA*NB products per multiply (NA = limbs of the wide partial result, NB = limbs
// of x; 3 and 1 at the default Q8.24 widths). A finished response waits in an
// output register; the next request is taken as soon as the result is written
// there. Register writes (csr index 0: epsilon, 1: max_iterations) are always
// ready and are to be made only while no request is in progress.
module bisection_cubic_root_top #(
   parameter int VALUE_WIDTH = bcr_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = bcr_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bcr_req_if.sink   req_ch,
   bcr_rsp_if.source rsp_ch,
   bcr_csr_if.sink   csr_ch
);

   bcr_pkg::cmd_type     cmd;
   bcr_pkg::dp_stat_type stat;

   // register port never stalls
   assign csr_ch.ready = 1'b1;

   bcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bcr_dp #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .left_end        (req_ch.left_end),
      .right_end       (req_ch.right_end),
      .csr_write       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_root        (rsp_ch.root),
      .rsp_final_width (rsp_ch.final_width),
      .rsp_iterations  (rsp_ch.iterations),
      .rsp_status      (rsp_ch.status)
   );

endmodule
